/* rtl/core/cau_pkg.sv */
// shared types and constants for the complex arithmetic unit
`default_nettype none
package cau_pkg;

  localparam int unsigned DataWidth = 32;

  localparam logic [1:0] OpAdd = 2'd0;
  localparam logic [1:0] OpSub = 2'd1;
  localparam logic [1:0] OpMul = 2'd2;
  localparam logic [1:0] OpDiv = 2'd3;

  localparam logic signed [DataWidth-1:0] SatMax = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic signed [DataWidth-1:0] SatMin = {1'b1, {(DataWidth-1){1'b0}}};

  // total cycles from the transfer edge to the result strobe edge
  localparam int unsigned Latency = DataWidth + 5;

  typedef struct packed {
    logic [1:0]                  req_type;
    logic signed [DataWidth-1:0] a_re;
    logic signed [DataWidth-1:0] a_im;
    logic signed [DataWidth-1:0] b_re;
    logic signed [DataWidth-1:0] b_im;
  } req_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] res_re;
    logic signed [DataWidth-1:0] res_im;
    logic                        overflow;
    logic                        div_by_zero;
  } res_t;

endpackage
`default_nettype wire

/* rtl/core/cau_div_pipe.sv */
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module cau_div_pipe #(
  parameter int unsigned NUM_W = 81,
  parameter int unsigned DEN_W = 64,
  parameter int unsigned Q_W   = 32
) (
  input  wire logic             clk_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [Q_W-1:0]   q_o
);

  localparam int unsigned CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [NUM_W-1:0] rem_q [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   q_q   [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int unsigned Sh = Q_W - 1 - k;
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   q_in;
    logic [CW-1:0]    rext;
    logic [CW-1:0]    dsh;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign q_in   = q_q[k-1];
    end

    assign rext = CW'(rem_in);
    assign dsh  = CW'(den_in) << Sh;
    assign ge   = (rext >= dsh);

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? NUM_W'(rext - dsh) : rem_in;
      den_q[k] <= den_in;
      q_q[k]   <= q_in | (Q_W'(ge) << Sh);
    end
  end

  assign q_o = q_q[Q_W-1];

endmodule
`default_nettype wire

/* rtl/core/complex_arithmetic_unit.sv */
// complex add, subtract, multiply and divide in signed fixed point
// a transfer passes the input, product, sum, saturation and divider registers to the output register
// throughput: one item per cycle, busy_o stays low
// the depth is set by the divider, one quotient bit per stage
// the receiver cannot stall; results show for one cycle on valid_o
// reset clears only the valid bits of the pipeline
`default_nettype none
module complex_arithmetic_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire cau_pkg::req_t req_i,
  output logic               busy_o,
  output logic               valid_o,
  output cau_pkg::res_t      res_o
);

  localparam int unsigned D   = cau_pkg::DataWidth;
  localparam int unsigned PW  = 2 * D;
  localparam int unsigned SW  = 2 * D + 1;
  localparam int unsigned NMW = SW + FRAC_BITS;
  localparam int unsigned CW3 = NMW + D;

  typedef struct packed {
    logic                div;
    logic                dz;
    logic signed [D-1:0] re;
    logic signed [D-1:0] im;
    logic                ovf;
    logic                neg_re;
    logic                neg_im;
    logic                pov_re;
    logic                pov_im;
  } side_t;

  assign busy_o = 1'b0;

  // input register
  logic          v0_q;
  cau_pkg::req_t in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= req_i;
  end

  // products and add/sub
  logic                v1_q;
  logic [1:0]          op1_q;
  logic signed [PW-1:0] ac_q, bd_q, ad_q, bc_q, cc_q, dd_q;
  logic signed [D:0]   as_re_q, as_im_q;
  logic signed [D:0]   as_re_d, as_im_d;

  always_comb begin
    if (in_q.req_type == cau_pkg::OpSub) begin
      as_re_d = {in_q.a_re[D-1], in_q.a_re} - {in_q.b_re[D-1], in_q.b_re};
      as_im_d = {in_q.a_im[D-1], in_q.a_im} - {in_q.b_im[D-1], in_q.b_im};
    end else begin
      as_re_d = {in_q.a_re[D-1], in_q.a_re} + {in_q.b_re[D-1], in_q.b_re};
      as_im_d = {in_q.a_im[D-1], in_q.a_im} + {in_q.b_im[D-1], in_q.b_im};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q   <= in_q.req_type;
    ac_q    <= in_q.a_re * in_q.b_re;
    bd_q    <= in_q.a_im * in_q.b_im;
    ad_q    <= in_q.a_re * in_q.b_im;
    bc_q    <= in_q.a_im * in_q.b_re;
    cc_q    <= in_q.b_re * in_q.b_re;
    dd_q    <= in_q.b_im * in_q.b_im;
    as_re_q <= as_re_d;
    as_im_q <= as_im_d;
  end

  // sums of products
  logic                 v2_q;
  logic [1:0]           op2_q;
  logic signed [SW-1:0] mre_q, mim_q, nre_q, nim_q;
  logic [PW-1:0]        den_q;
  logic signed [D:0]    as2_re_q, as2_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op2_q    <= op1_q;
    mre_q    <= SW'(ac_q) - SW'(bd_q);
    mim_q    <= SW'(ad_q) + SW'(bc_q);
    nre_q    <= SW'(ac_q) + SW'(bd_q);
    nim_q    <= SW'(bc_q) - SW'(ad_q);
    den_q    <= cc_q + dd_q;
    as2_re_q <= as_re_q;
    as2_im_q <= as_im_q;
  end

  // saturation of direct results and divider setup
  logic                 v3_q;
  side_t                side3_d, side3_q;
  logic [NMW-1:0]       nm_re_d, nm_im_d, nm_re_q, nm_im_q;
  logic [PW-1:0]        den3_q;
  logic signed [SW-1:0] sh_re, sh_im;
  logic [SW-1:0]        mag_re, mag_im;
  logic [CW3-1:0]       den_lim;
  logic                 fit_re, fit_im;

  always_comb begin
    sh_re   = mre_q >>> FRAC_BITS;
    sh_im   = mim_q >>> FRAC_BITS;
    mag_re  = nre_q[SW-1] ? (~nre_q + 1'b1) : nre_q;
    mag_im  = nim_q[SW-1] ? (~nim_q + 1'b1) : nim_q;
    nm_re_d = NMW'(mag_re) << FRAC_BITS;
    nm_im_d = NMW'(mag_im) << FRAC_BITS;
    den_lim = CW3'(den_q) << D;

    side3_d        = '0;
    side3_d.div    = (op2_q == cau_pkg::OpDiv);
    side3_d.dz     = side3_d.div && (den_q == '0);
    side3_d.neg_re = nre_q[SW-1];
    side3_d.neg_im = nim_q[SW-1];
    side3_d.pov_re = (CW3'(nm_re_d) >= den_lim);
    side3_d.pov_im = (CW3'(nm_im_d) >= den_lim);

    if (op2_q == cau_pkg::OpMul) begin
      fit_re = (&sh_re[SW-1:D-1]) || !(|sh_re[SW-1:D-1]);
      fit_im = (&sh_im[SW-1:D-1]) || !(|sh_im[SW-1:D-1]);
      side3_d.re = fit_re ? sh_re[D-1:0] : (sh_re[SW-1] ? cau_pkg::SatMin : cau_pkg::SatMax);
      side3_d.im = fit_im ? sh_im[D-1:0] : (sh_im[SW-1] ? cau_pkg::SatMin : cau_pkg::SatMax);
    end else begin
      fit_re = (as2_re_q[D] == as2_re_q[D-1]);
      fit_im = (as2_im_q[D] == as2_im_q[D-1]);
      side3_d.re = fit_re ? as2_re_q[D-1:0] : (as2_re_q[D] ? cau_pkg::SatMin : cau_pkg::SatMax);
      side3_d.im = fit_im ? as2_im_q[D-1:0] : (as2_im_q[D] ? cau_pkg::SatMin : cau_pkg::SatMax);
    end
    side3_d.ovf = !fit_re || !fit_im;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side3_q <= side3_d;
    nm_re_q <= nm_re_d;
    nm_im_q <= nm_im_d;
    den3_q  <= den_q;
  end

  // dividers and matching side line
  logic [D-1:0] q_re, q_im;
  side_t        side_q [D];
  logic [D-1:0] dv_q;

  cau_div_pipe #(.NUM_W(NMW), .DEN_W(PW), .Q_W(D)) u_div_re (
    .clk_i (clk_i),
    .num_i (nm_re_q),
    .den_i (den3_q),
    .q_o   (q_re)
  );

  cau_div_pipe #(.NUM_W(NMW), .DEN_W(PW), .Q_W(D)) u_div_im (
    .clk_i (clk_i),
    .num_i (nm_im_q),
    .den_i (den3_q),
    .q_o   (q_im)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= '0;
    end else begin
      dv_q <= {dv_q[D-2:0], v3_q};
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side3_q;
    for (int k = 1; k < D; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  // final selection
  side_t               sl;
  cau_pkg::res_t       res_d;
  logic signed [D-1:0] dre, dim;
  logic                dovf_re, dovf_im;
  logic                valid_q;
  cau_pkg::res_t       res_q;

  always_comb begin
    sl = side_q[D-1];
    if (sl.neg_re) begin
      dovf_re = sl.pov_re || (q_re > cau_pkg::SatMin);
      dre     = dovf_re ? cau_pkg::SatMin : D'(D'(0) - q_re);
    end else begin
      dovf_re = sl.pov_re || q_re[D-1];
      dre     = dovf_re ? cau_pkg::SatMax : q_re;
    end
    if (sl.neg_im) begin
      dovf_im = sl.pov_im || (q_im > cau_pkg::SatMin);
      dim     = dovf_im ? cau_pkg::SatMin : D'(D'(0) - q_im);
    end else begin
      dovf_im = sl.pov_im || q_im[D-1];
      dim     = dovf_im ? cau_pkg::SatMax : q_im;
    end

    res_d = '0;
    if (!sl.div) begin
      res_d.res_re   = sl.re;
      res_d.res_im   = sl.im;
      res_d.overflow = sl.ovf;
    end else if (sl.dz) begin
      res_d.div_by_zero = 1'b1;
    end else begin
      res_d.res_re   = dre;
      res_d.res_im   = dim;
      res_d.overflow = dovf_re || dovf_im;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= dv_q[D-1];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire

/* rtl/core/cau_checker.sv */
// port level checks for the complex arithmetic unit and their bind
`default_nettype none
module cau_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start_i,
  input wire cau_pkg::req_t req_i,
  input wire logic          busy_o,
  input wire logic          valid_o,
  input wire cau_pkg::res_t res_o
);

  logic unused_req;
  assign unused_req = ^req_i;

  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##(cau_pkg::Latency) valid_o)
    else $error("transfer without result at fixed latency");

  a_latency_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, cau_pkg::Latency))
    else $error("result without matching transfer");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.div_by_zero |->
      res_o.res_re == '0 && res_o.res_im == '0 && !res_o.overflow)
    else $error("zero divisor result not clean");

  a_ovf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && res_o.overflow |->
      res_o.res_re == cau_pkg::SatMax || res_o.res_re == cau_pkg::SatMin ||
      res_o.res_im == cau_pkg::SatMax || res_o.res_im == cau_pkg::SatMin)
    else $error("overflow without saturated part");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
`default_nettype wire

/* dv/tb.sv */
// testbench for the complex arithmetic unit: directed table then random items
`timescale 1ns / 1ps
module tb;

  localparam int unsigned DW = cau_pkg::DataWidth;
  localparam int unsigned FracBits = 16;
  localparam int unsigned NumRandom = 1800;
  localparam int unsigned WatchdogLimit = 2000;

  typedef struct {
    cau_pkg::req_t req;
    logic          has_res;
    cau_pkg::res_t res;
  } vec_t;

  logic          clk_i;
  logic          rst_ni;
  logic          start_i;
  cau_pkg::req_t req_i;
  logic          busy_o;
  logic          valid_o;
  cau_pkg::res_t res_o;

  cau_pkg::res_t expected_q[$];
  int            errors;
  int            idle_cycles = 0;
  logic          sending;
  vec_t          vecs[$];

  complex_arithmetic_unit #(.FRAC_BITS(FracBits)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [DW-1:0] clamp(logic signed [191:0] v,
                                                 inout logic ovf);
    if (v > 192'(signed'(cau_pkg::SatMax))) begin
      ovf = 1'b1;
      return cau_pkg::SatMax;
    end
    if (v < 192'(signed'(cau_pkg::SatMin))) begin
      ovf = 1'b1;
      return cau_pkg::SatMin;
    end
    return v[DW-1:0];
  endfunction

  // truncate toward zero
  function automatic logic signed [191:0] quot(logic signed [191:0] n,
                                               logic signed [191:0] d);
    logic signed [191:0] mag;
    mag = (n < 0 ? -n : n) / d;
    return n < 0 ? -mag : mag;
  endfunction

  function automatic cau_pkg::res_t complex_result(cau_pkg::req_t r);
    logic signed [191:0] a, b, c, d, re, im, den;
    cau_pkg::res_t o;
    a = 192'(r.a_re);
    b = 192'(r.a_im);
    c = 192'(r.b_re);
    d = 192'(r.b_im);
    o = '0;
    case (r.req_type)
      cau_pkg::OpAdd: begin
        re = a + c;
        im = b + d;
      end
      cau_pkg::OpSub: begin
        re = a - c;
        im = b - d;
      end
      cau_pkg::OpMul: begin
        re = (a * c - b * d) >>> FracBits;
        im = (a * d + b * c) >>> FracBits;
      end
      default: begin
        den = c * c + d * d;
        if (den == 0) begin
          o.div_by_zero = 1'b1;
          return o;
        end
        re = quot((a * c + b * d) <<< FracBits, den);
        im = quot((b * c - a * d) <<< FracBits, den);
      end
    endcase
    o.res_re = clamp(re, o.overflow);
    o.res_im = clamp(im, o.overflow);
    return o;
  endfunction

  function automatic logic signed [DW-1:0] rand_part();
    case ($urandom_range(0, 5))
      0: return cau_pkg::SatMax;
      1: return cau_pkg::SatMin;
      2: return DW'($signed($urandom_range(0, 2 * 65536)) - 65536);
      3: return DW'($signed($urandom_range(0, 511)) - 256);
      4: return 0;
      default: return $urandom;
    endcase
  endfunction

  function automatic cau_pkg::req_t rand_req();
    cau_pkg::req_t r;
    r.req_type = 2'($urandom_range(0, 3));
    r.a_re = rand_part();
    r.a_im = rand_part();
    r.b_re = rand_part();
    r.b_im = rand_part();
    if (r.req_type == cau_pkg::OpDiv && $urandom_range(0, 15) == 0) begin
      r.b_re = 0;
      r.b_im = 0;
    end
    return r;
  endfunction

  function automatic vec_t row(logic [1:0] op, logic signed [DW-1:0] ar,
                               logic signed [DW-1:0] ai,
                               logic signed [DW-1:0] br,
                               logic signed [DW-1:0] bi, logic has_res,
                               logic signed [DW-1:0] rr,
                               logic signed [DW-1:0] ri, logic ovf,
                               logic dz);
    vec_t v;
    v.req = '{op, ar, ai, br, bi};
    v.has_res = has_res;
    v.res = '{rr, ri, ovf, dz};
    return v;
  endfunction

  task automatic send(cau_pkg::req_t r);
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expected_q.push_back(complex_result(r));
  endtask

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t: expected no result actual %p", $time, res_o);
        errors++;
      end else begin
        cau_pkg::res_t exp_res;
        exp_res = expected_q.pop_front();
        if (res_o.res_re !== exp_res.res_re || res_o.res_im !== exp_res.res_im ||
            res_o.overflow !== exp_res.overflow ||
            res_o.div_by_zero !== exp_res.div_by_zero) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_res, res_o);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o || !rst_ni) idle_cycles <= 0;
    else if (sending || expected_q.size() != 0) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int n;
    errors = 0;
    sending = 1'b0;
    start_i = 1'b0;
    req_i = '0;
    rst_ni = 1'b0;
    vecs.push_back(row(cau_pkg::OpAdd, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                       32'hffff_0000, 1, 32'h0004_0000, 32'h0001_0000, 0, 0));
    vecs.push_back(row(cau_pkg::OpAdd, cau_pkg::SatMax, cau_pkg::SatMin, 1, -1, 1,
                       cau_pkg::SatMax, cau_pkg::SatMin, 1, 0));
    vecs.push_back(row(cau_pkg::OpAdd, cau_pkg::SatMax, cau_pkg::SatMin,
                       cau_pkg::SatMin, cau_pkg::SatMax, 1, -1, -1, 0, 0));
    vecs.push_back(row(cau_pkg::OpSub, cau_pkg::SatMin, cau_pkg::SatMax, 1, -1, 1,
                       cau_pkg::SatMin, cau_pkg::SatMax, 1, 0));
    vecs.push_back(row(cau_pkg::OpSub, 0, 0, cau_pkg::SatMin, 0, 1,
                       cau_pkg::SatMax, 0, 1, 0));
    vecs.push_back(row(cau_pkg::OpMul, 32'h0002_0000, 0, 32'h0003_0000, 0, 1,
                       32'h0006_0000, 0, 0, 0));
    vecs.push_back(row(cau_pkg::OpMul, cau_pkg::SatMax, cau_pkg::SatMax,
                       cau_pkg::SatMax, cau_pkg::SatMin, 1,
                       cau_pkg::SatMax, 32'hffff_8000, 1, 0));
    vecs.push_back(row(cau_pkg::OpMul, cau_pkg::SatMin, cau_pkg::SatMin,
                       cau_pkg::SatMin, cau_pkg::SatMin, 0, 0, 0, 0, 0));
    vecs.push_back(row(cau_pkg::OpMul, -1, 0, 1, 0, 0, 0, 0, 0, 0));
    vecs.push_back(row(cau_pkg::OpMul, 1, 1, 1, 1, 0, 0, 0, 0, 0));
    vecs.push_back(row(cau_pkg::OpDiv, 32'h0001_0000, 32'h0001_0000, 0, 0, 1,
                       0, 0, 0, 1));
    vecs.push_back(row(cau_pkg::OpDiv, cau_pkg::SatMax, cau_pkg::SatMin, 0, 0, 1,
                       0, 0, 0, 1));
    vecs.push_back(row(cau_pkg::OpDiv, 32'h0006_0000, 0, 32'h0002_0000, 0, 1,
                       32'h0003_0000, 0, 0, 0));
    vecs.push_back(row(cau_pkg::OpDiv, cau_pkg::SatMax, cau_pkg::SatMax, 1, 0, 1,
                       cau_pkg::SatMax, cau_pkg::SatMax, 1, 0));
    vecs.push_back(row(cau_pkg::OpDiv, cau_pkg::SatMin, cau_pkg::SatMax, 1, 1, 0,
                       0, 0, 0, 0));
    vecs.push_back(row(cau_pkg::OpDiv, -1, 1, 32'h0003_0000, 0, 0, 0, 0, 0, 0));
    vecs.push_back(row(cau_pkg::OpDiv, 1, -1, cau_pkg::SatMin, cau_pkg::SatMin, 0,
                       0, 0, 0, 0));
    vecs.push_back(row(cau_pkg::OpDiv, 32'h0001_0000, 0, 0, 32'h0001_0000, 0,
                       0, 0, 0, 0));
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    sending = 1'b1;
    foreach (vecs[i]) begin
      @(negedge clk_i);
      if (vecs[i].has_res && complex_result(vecs[i].req) !== vecs[i].res) begin
        $display("%0t: table row %0d expected %p actual %p", $time, i, vecs[i].res,
                 complex_result(vecs[i].req));
        errors++;
      end
      send(vecs[i].req);
    end
    n = 0;
    while (n < NumRandom) begin
      @(negedge clk_i);
      if (n < NumRandom - 200 && $urandom_range(0, 5) == 0) begin
        start_i <= 1'b0;
        req_i   <= rand_req();
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end
      send(rand_req());
      n++;
    end
    @(negedge clk_i);
    start_i <= 1'b0;
    sending = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (cau_pkg::Latency + 10) @(posedge clk_i);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
rtl/core/cau_pkg.sv
rtl/core/cau_div_pipe.sv
rtl/core/complex_arithmetic_unit.sv
rtl/core/cau_checker.sv
dv/tb.sv
